[hdl/virtual_stick_axis_mapper_top_defines.svh]
// assertion macros for the virtual stick axis mapper checker
// expects clk_i and rst_ni in the scope of each use
`ifndef VIRTUAL_STICK_AXIS_MAPPER_TOP_DEFINES_SVH
`define VIRTUAL_STICK_AXIS_MAPPER_TOP_DEFINES_SVH

// same-cycle implication
`define VSAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VSAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vsam_pkg.sv]
// shared types and constants of the virtual stick axis mapper
// no dependencies
package vsam_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int AXIS_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int IN_TDATA_W     = 48;
  localparam int OUT_TDATA_W    = 64;

  localparam logic [15:0] THRESH = 16'd6554;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AREA_CX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_CY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CMODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONLY_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd6;

  // key states
  localparam logic [1:0] KS_UP       = 2'd0;
  localparam logic [1:0] KS_PRESSED  = 2'd1;
  localparam logic [1:0] KS_DOWN     = 2'd2;
  localparam logic [1:0] KS_RELEASED = 2'd3;

  // center modes
  localparam logic [1:0] CM_AREA     = 2'd0;
  localparam logic [1:0] CM_ACT      = 2'd1;
  localparam logic [1:0] CM_SWIPE    = 2'd2;
  localparam logic [1:0] CM_AREA_ALT = 2'd3;  // spare code, acts as area midpoint

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LERP_X,
    ST_LERP_Y,
    ST_LERP_UPD,
    ST_PREP,
    ST_OFFSET,
    ST_DIV_AY,
    ST_NORM,
    ST_SQ_Y,
    ST_SQ_SUM,
    ST_SQRT,
    ST_BIG,
    ST_DIV_STR,
    ST_DIV_NX,
    ST_DIV_NY,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_FIN,
    ST_DONE
  } state_e;

endpackage

[hdl/virtual_stick_axis_mapper_top.sv]
// virtual stick axis mapper: touch position to four half-axis deflections
// depends on vsam_pkg
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: touch_x, touch_y, frame_time; tuser: key_state
// m_axis    out  m_axis_tvalid/tready    tdata: left, right, up, down; tuser: stick_active
// cfg       in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// an active item runs the divide of the y offset, the root and three fraction divides
// before the next ready; swipe mode adds the center update and each normalizing shift a step;
// the shared subtractor yields one quotient or root bit per cycle
// a zero offset skips the fraction divides and the multiplies
// a disabled or key-up item goes straight to the result stage
// reset clears config, stick state and control at once; no clearing pass
// a finished result sits in the output register while the next item is taken;
// a second finished result waits until that register is free
module virtual_stick_axis_mapper_top #(
  parameter int COORD_BITS = vsam_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [vsam_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // touch_x, touch_y, frame_time
  input  logic [1:0]                          s_axis_tuser,  // key_state
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [vsam_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // left, right, up, down
  output logic                                m_axis_tuser,  // stick_active
  input  logic                                cfg_we_i,
  input  logic [vsam_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [vsam_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int CW     = COORD_BITS;
  localparam int AW     = CW + 12;
  localparam int QW     = (AW > 32) ? AW : 32;
  localparam int SW     = $clog2(AW);
  localparam int CNTW   = $clog2(QW + 1);
  localparam int BW     = AW + 32;
  localparam int UP_SH  = (CW >= 16) ? CW - 16 : 0;
  localparam int DN_SH  = (CW < 16) ? 16 - CW : 0;
  localparam int NDIGIT = 17;  // quotient bits of a fraction divide

  // q0.16 to internal coordinate format
  function automatic logic [CW-1:0] to_coord(input logic [15:0] v);
    logic [39:0] t;
    t = (40'(v) << UP_SH) >> DN_SH;
    return t[CW-1:0];
  endfunction

  // move c toward t by the scaled step in p
  function automatic logic [CW-1:0] lerp_upd(input logic [CW-1:0] c, input logic [CW-1:0] t,
                                             input logic [63:0] p);
    logic [CW-1:0] step;
    step = p[CW+15:16];
    return (t >= c) ? c + step : c - step;
  endfunction

  // product to half-axis value with saturation and dead zone
  function automatic logic [15:0] aval(input logic [63:0] p);
    logic [17:0] v;
    v = p[33:16];
    if (v > 18'd65535) return 16'hFFFF;
    else if (v < 18'(vsam_pkg::THRESH)) return 16'd0;
    else return v[15:0];
  endfunction

  // configuration
  logic [15:0] area_cx_q, area_cy_q, radius_q, aspect_q;
  logic [1:0]  cmode_q;
  logic        only_max_q, enable_q;

  // stick state
  logic [CW-1:0] center_x_q, center_y_q, last_x_q, last_y_q;

  // item and work registers
  vsam_pkg::state_e state_q, state_d;
  logic [1:0]    ks_q;
  logic [CW-1:0] tx_q, ty_q;
  logic [15:0]   ft_q;
  logic          xneg_q, yneg_q;
  logic [AW-1:0] ax_q, ay_q;
  logic [SW-1:0] s_q;
  logic [31:0]   len_q;
  logic [16:0]   str_q, nx_q, ny_q;
  logic [15:0]   vx_q;
  logic [63:0]   prod_q, acc_q;

  // shared divide / root unit
  logic [33:0]     rem_q;
  logic [AW-1:0]   num_q;
  logic [QW-1:0]   quo_q;
  logic [31:0]     divd_q;
  logic [CNTW-1:0] cnt_q;

  // result and output register
  logic [63:0] res_q, out_data_q;
  logic        res_act_q, out_act_q, out_valid_q;

  // combinational helpers
  logic [17:0]   ft4;
  logic [16:0]   w_c;
  logic [CW-1:0] dxl, dyl, absx, absy, rad_c, big_c;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  logic [32:0]   div_t;
  logic [35:0]   sq_t, sub_a, sub_b;
  logic [36:0]   sub_diff;
  logic          ge, is_sqrt, last_step, ovf, out_free, in_acc;
  logic [QW-1:0] q_next;
  logic [33:0]   rem_next;
  logic [BW-1:0] big_w;
  logic [15:0]   asp_c, rad16, vy_c;
  logic          drive_x, drive_y;
  logic [63:0]   res_c;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign ft4 = {ft_q, 2'b00};
  assign w_c = (ft4 > 18'd65536) ? 17'h10000 : ft4[16:0];
  assign dxl = (last_x_q >= center_x_q) ? last_x_q - center_x_q : center_x_q - last_x_q;
  assign dyl = (last_y_q >= center_y_q) ? last_y_q - center_y_q : center_y_q - last_y_q;
  assign absx = (tx_q >= center_x_q) ? tx_q - center_x_q : center_x_q - tx_q;
  assign absy = (ty_q >= center_y_q) ? ty_q - center_y_q : center_y_q - ty_q;
  assign asp_c = (aspect_q == 16'd0) ? 16'd1 : aspect_q;
  assign rad16 = (radius_q == 16'd0) ? 16'd1 : radius_q;

  always_comb begin
    rad_c = to_coord(rad16);
    if (rad_c == '0) rad_c = CW'(1);
  end

  assign big_w = BW'(len_q) << s_q;
  assign big_c = (big_w > BW'(rad_c)) ? rad_c : big_w[CW-1:0];
  assign ovf   = ((ax_q | ay_q) >> 31) != '0;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      vsam_pkg::ST_LERP_X: begin mul_a = 32'(dxl); mul_b = 32'(w_c); end
      vsam_pkg::ST_LERP_Y: begin mul_a = 32'(dyl); mul_b = 32'(w_c); end
      vsam_pkg::ST_NORM:   begin mul_a = 32'(ax_q); mul_b = 32'(ax_q); end
      vsam_pkg::ST_SQ_Y:   begin mul_a = 32'(ay_q); mul_b = 32'(ay_q); end
      vsam_pkg::ST_MUL_X:  begin mul_a = 32'(nx_q); mul_b = 32'(str_q); end
      vsam_pkg::ST_MUL_Y:  begin mul_a = 32'(ny_q); mul_b = 32'(str_q); end
      default: ;
    endcase
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // shared subtractor: restoring divide or digit-by-digit root
  assign is_sqrt  = (state_q == vsam_pkg::ST_SQRT);
  assign div_t    = {rem_q[31:0], num_q[AW-1]};
  assign sq_t     = {rem_q, acc_q[63:62]};
  assign sub_a    = is_sqrt ? sq_t : 36'(div_t);
  assign sub_b    = is_sqrt ? 36'({quo_q[31:0], 2'b01}) : 36'(divd_q);
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge       = !sub_diff[36];
  assign q_next   = {quo_q[QW-2:0], ge};
  assign rem_next = ge ? sub_diff[33:0] : sub_a[33:0];
  assign last_step = (cnt_q == CNTW'(1));

  assign vy_c    = aval(prod_q);
  assign drive_x = !only_max_q || (nx_q >= ny_q);
  assign drive_y = !only_max_q || (nx_q < ny_q);

  // final result word, undriven half-axes stay zero
  always_comb begin
    res_c = '0;
    if (drive_x) begin
      if (xneg_q) res_c[15:0]  = vx_q;
      else        res_c[31:16] = vx_q;
    end
    if (drive_y) begin
      if (yneg_q) res_c[47:32] = vy_c;
      else        res_c[63:48] = vy_c;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_cx_q  <= '0;
      area_cy_q  <= '0;
      radius_q   <= 16'd1;
      aspect_q   <= 16'd4096;
      cmode_q    <= vsam_pkg::CM_AREA;
      only_max_q <= 1'b0;
      enable_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vsam_pkg::REG_AREA_CX:  area_cx_q  <= cfg_wdata_i;
        vsam_pkg::REG_AREA_CY:  area_cy_q  <= cfg_wdata_i;
        vsam_pkg::REG_RADIUS:   radius_q   <= cfg_wdata_i;
        vsam_pkg::REG_ASPECT:   aspect_q   <= cfg_wdata_i;
        vsam_pkg::REG_CMODE:    cmode_q    <= cfg_wdata_i[1:0];
        vsam_pkg::REG_ONLY_MAX: only_max_q <= cfg_wdata_i[0];
        vsam_pkg::REG_ENABLE:   enable_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vsam_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vsam_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!enable_q || s_axis_tuser == vsam_pkg::KS_UP) state_d = vsam_pkg::ST_DONE;
          else if (cmode_q == vsam_pkg::CM_SWIPE) state_d = vsam_pkg::ST_LERP_X;
          else state_d = vsam_pkg::ST_PREP;
        end
      end
      vsam_pkg::ST_LERP_X:   state_d = vsam_pkg::ST_LERP_Y;
      vsam_pkg::ST_LERP_Y:   state_d = vsam_pkg::ST_LERP_UPD;
      vsam_pkg::ST_LERP_UPD: state_d = vsam_pkg::ST_PREP;
      vsam_pkg::ST_PREP:     state_d = vsam_pkg::ST_OFFSET;
      vsam_pkg::ST_OFFSET:   state_d = vsam_pkg::ST_DIV_AY;
      vsam_pkg::ST_DIV_AY:   if (last_step) state_d = vsam_pkg::ST_NORM;
      vsam_pkg::ST_NORM:     if (!ovf) state_d = vsam_pkg::ST_SQ_Y;
      vsam_pkg::ST_SQ_Y:     state_d = vsam_pkg::ST_SQ_SUM;
      vsam_pkg::ST_SQ_SUM:   state_d = vsam_pkg::ST_SQRT;
      vsam_pkg::ST_SQRT:     if (last_step) state_d = vsam_pkg::ST_BIG;
      vsam_pkg::ST_BIG: begin
        state_d = (len_q == '0) ? vsam_pkg::ST_DONE : vsam_pkg::ST_DIV_STR;
      end
      vsam_pkg::ST_DIV_STR:  if (last_step) state_d = vsam_pkg::ST_DIV_NX;
      vsam_pkg::ST_DIV_NX:   if (last_step) state_d = vsam_pkg::ST_DIV_NY;
      vsam_pkg::ST_DIV_NY:   if (last_step) state_d = vsam_pkg::ST_MUL_X;
      vsam_pkg::ST_MUL_X:    state_d = vsam_pkg::ST_MUL_Y;
      vsam_pkg::ST_MUL_Y:    state_d = vsam_pkg::ST_MUL_FIN;
      vsam_pkg::ST_MUL_FIN:  state_d = vsam_pkg::ST_DONE;
      vsam_pkg::ST_DONE:     if (out_free) state_d = vsam_pkg::ST_IDLE;
      default:               state_d = vsam_pkg::ST_IDLE;
    endcase
  end

  // stick state, only touched by active items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      last_x_q   <= '0;
      last_y_q   <= '0;
    end else begin
      case (state_q)
        vsam_pkg::ST_LERP_Y:   center_x_q <= lerp_upd(center_x_q, last_x_q, prod_q);
        vsam_pkg::ST_LERP_UPD: center_y_q <= lerp_upd(center_y_q, last_y_q, prod_q);
        vsam_pkg::ST_PREP: begin
          last_x_q <= tx_q;
          last_y_q <= ty_q;
          if (ks_q == vsam_pkg::KS_PRESSED) begin
            if (cmode_q == vsam_pkg::CM_ACT || cmode_q == vsam_pkg::CM_SWIPE) begin
              center_x_q <= tx_q;
              center_y_q <= ty_q;
            end else begin
              center_x_q <= to_coord(area_cx_q);
              center_y_q <= to_coord(area_cy_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath payload registers
  always_ff @(posedge clk_i) begin
    case (state_q) inside
      vsam_pkg::ST_IDLE: begin
        ks_q      <= s_axis_tuser;
        tx_q      <= to_coord(s_axis_tdata[15:0]);
        ty_q      <= to_coord(s_axis_tdata[31:16]);
        ft_q      <= s_axis_tdata[47:32];
        res_q     <= '0;
        res_act_q <= enable_q && (s_axis_tuser != vsam_pkg::KS_UP);
        s_q       <= '0;
      end
      vsam_pkg::ST_LERP_X: prod_q <= mul_p;
      vsam_pkg::ST_LERP_Y: prod_q <= mul_p;
      vsam_pkg::ST_OFFSET: begin
        xneg_q <= tx_q < center_x_q;
        yneg_q <= ty_q < center_y_q;
        ax_q   <= AW'(absx);
        rem_q  <= '0;
        num_q  <= {absy, 12'd0};
        divd_q <= 32'(asp_c);
        quo_q  <= '0;
        cnt_q  <= CNTW'(AW);
      end
      vsam_pkg::ST_DIV_AY: begin
        rem_q <= rem_next;
        num_q <= num_q << 1;
        quo_q <= q_next;
        cnt_q <= cnt_q - CNTW'(1);
        if (last_step) ay_q <= q_next[AW-1:0];
      end
      vsam_pkg::ST_NORM: begin
        if (ovf) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
          s_q  <= s_q + SW'(1);
        end else begin
          prod_q <= mul_p;
        end
      end
      vsam_pkg::ST_SQ_Y: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      vsam_pkg::ST_SQ_SUM: begin
        acc_q <= acc_q + prod_q;
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CNTW'(32);
      end
      vsam_pkg::ST_SQRT: begin
        rem_q <= rem_next;
        acc_q <= acc_q << 2;
        quo_q <= q_next;
        cnt_q <= cnt_q - CNTW'(1);
        if (last_step) len_q <= q_next[31:0];
      end
      vsam_pkg::ST_BIG: begin
        // strength = big * 2^16 / radius
        rem_q  <= 34'(big_c >> 1);
        num_q  <= {big_c[0], {(AW-1){1'b0}}};
        divd_q <= 32'(rad_c);
        quo_q  <= '0;
        cnt_q  <= CNTW'(NDIGIT);
      end
      vsam_pkg::ST_DIV_STR, vsam_pkg::ST_DIV_NX, vsam_pkg::ST_DIV_NY: begin
        if (last_step) begin
          // start the next fraction divide by the length
          divd_q <= len_q;
          quo_q  <= '0;
          cnt_q  <= CNTW'(NDIGIT);
          if (state_q == vsam_pkg::ST_DIV_STR) begin
            str_q <= q_next[16:0];
            rem_q <= 34'(32'(ax_q) >> 1);
            num_q <= {ax_q[0], {(AW-1){1'b0}}};
          end else begin
            rem_q <= 34'(32'(ay_q) >> 1);
            num_q <= {ay_q[0], {(AW-1){1'b0}}};
            if (state_q == vsam_pkg::ST_DIV_NX) nx_q <= q_next[16:0];
            else ny_q <= q_next[16:0];
          end
        end else begin
          rem_q <= rem_next;
          num_q <= num_q << 1;
          quo_q <= q_next;
          cnt_q <= cnt_q - CNTW'(1);
        end
      end
      vsam_pkg::ST_MUL_X: prod_q <= mul_p;
      vsam_pkg::ST_MUL_Y: begin
        vx_q   <= aval(prod_q);
        prod_q <= mul_p;
      end
      vsam_pkg::ST_MUL_FIN: res_q <= res_c;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == vsam_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == vsam_pkg::ST_DONE && out_free) begin
      out_data_q <= res_q;
      out_act_q  <= res_act_q;
    end
  end

  assign s_axis_tready = (state_q == vsam_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_act_q;

endmodule

[hdl/vsam_checker.sv]
// port-level checks of the virtual stick axis mapper, bound to the top level
// depends on vsam_pkg and virtual_stick_axis_mapper_top_defines.svh
`include "virtual_stick_axis_mapper_top_defines.svh"

module vsam_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [vsam_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // left, right, up, down
  input logic                             m_axis_tuser   // stick_active
);

  localparam int AW = vsam_pkg::AXIS_W;

  logic [AW-1:0] left_v, right_v, up_v, down_v;

  assign left_v  = m_axis_tdata[AW-1:0];
  assign right_v = m_axis_tdata[2*AW-1:AW];
  assign up_v    = m_axis_tdata[3*AW-1:2*AW];
  assign down_v  = m_axis_tdata[4*AW-1:3*AW];

  // one item at a time
  `VSAM_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                    "input taken while an item is in work")

  // a stalled result holds
  `VSAM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                    "stalled result changed")

  // inactive stick gives zero deflection
  `VSAM_ASSERT_NOW(a_idle_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0,
                   "inactive result with deflection")

  // opposite half-axes never both driven
  `VSAM_ASSERT_NOW(a_opposite, m_axis_tvalid,
                   (left_v == '0 || right_v == '0) && (up_v == '0 || down_v == '0),
                   "opposite half-axes both nonzero")

endmodule

bind virtual_stick_axis_mapper_top vsam_checker u_vsam_checker (.*);

[bench/virtual_stick_axis_mapper_top_tb.sv]
// self-checking bench for the virtual stick axis mapper: touch transfers in, axis transfers out
// depends on vsam_pkg and virtual_stick_axis_mapper_top; predicts each result in a local model
module virtual_stick_axis_mapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = vsam_pkg::COORD_BITS_DEF;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] up;
    logic [15:0] down;
    logic        active;
  } axes_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [vsam_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;  // touch_x, touch_y, frame_time
  logic [1:0] s_axis_tuser = '0;                        // key_state
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [vsam_pkg::OUT_TDATA_W-1:0] m_axis_tdata;      // left, right, up, down
  logic m_axis_tuser;                                   // stick_active
  logic cfg_we_i = 1'b0;
  logic [vsam_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [vsam_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  virtual_stick_axis_mapper_top dut (.*);

  // model copy of registers and stick state
  logic [15:0] m_acx, m_acy, m_rad, m_asp;
  logic [1:0]  m_mode;
  logic        m_onlymax, m_en;
  logic [63:0] m_cx, m_cy, m_lx, m_ly;

  axes_t expected_axes[$];
  int    fails = 0;
  int    cycles = 0;
  int    send_idle_pct = 0;   // sender gap chance in percent
  int    recv_stall_pct = 0;  // receiver stall chance in percent
  bit    hold_off = 1'b0;     // long receiver hold-off in progress

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // q0.16 to the internal coordinate format
  function automatic logic [63:0] coord_of(logic [15:0] v);
    logic [63:0] t;
    t = 64'(v);
    if (CB >= 16) t = t << (CB - 16);
    else t = t >> (16 - CB);
    return t;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != '0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] move_toward(logic [63:0] c, logic [63:0] t, logic [63:0] w);
    if (t >= c) return c + (((t - c) * w) >> 16);
    return c - (((c - t) * w) >> 16);
  endfunction

  function automatic logic [15:0] deflection(logic [63:0] n, logic [63:0] s);
    logic [63:0] v;
    v = (n * s) >> 16;
    if (v > 64'd65535) v = 64'd65535;
    if (v < 64'(vsam_pkg::THRESH)) v = '0;
    return v[15:0];
  endfunction

  // computes the axis result of one touch transfer and advances the stick state
  function automatic axes_t predict_axes(logic [1:0] ks, logic [15:0] tx16, logic [15:0] ty16,
                                         logic [15:0] ft);
    axes_t r;
    logic [63:0] tx, ty, ax, ay, asp, rad, len, big, str, nx, ny, w;
    logic xneg, yneg;
    int s;
    r = '0;
    s = 0;
    if (!m_en || ks == vsam_pkg::KS_UP) return r;
    r.active = 1'b1;
    tx = coord_of(tx16);
    ty = coord_of(ty16);
    if (m_mode == vsam_pkg::CM_SWIPE) begin
      w = 64'(ft) * 64'd4;
      if (w > 64'd65536) w = 64'd65536;
      m_cx = move_toward(m_cx, m_lx, w);
      m_cy = move_toward(m_cy, m_ly, w);
    end
    m_lx = tx;
    m_ly = ty;
    if (ks == vsam_pkg::KS_PRESSED) begin
      if (m_mode == vsam_pkg::CM_ACT || m_mode == vsam_pkg::CM_SWIPE) begin
        m_cx = tx;
        m_cy = ty;
      end else begin
        m_cx = coord_of(m_acx);
        m_cy = coord_of(m_acy);
      end
    end
    xneg = tx < m_cx;
    yneg = ty < m_cy;
    ax = xneg ? m_cx - tx : tx - m_cx;
    ay = yneg ? m_cy - ty : ty - m_cy;
    asp = (m_asp != '0) ? 64'(m_asp) : 64'd1;
    ay = (ay << 12) / asp;
    while (((ax | ay) >> 31) != '0) begin
      ax = ax >> 1;
      ay = ay >> 1;
      s++;
    end
    len = int_sqrt(ax * ax + ay * ay);
    if (len == '0) return r;
    rad = coord_of((m_rad != '0) ? m_rad : 16'd1);
    if (rad == '0) rad = 64'd1;
    big = len << s;
    if (big > rad) big = rad;
    str = (big << 16) / rad;
    nx = (ax << 16) / len;
    ny = (ay << 16) / len;
    if (m_onlymax) begin
      if (nx >= ny) begin
        if (xneg) r.left = deflection(nx, str);
        else r.right = deflection(nx, str);
      end else begin
        if (yneg) r.up = deflection(ny, str);
        else r.down = deflection(ny, str);
      end
    end else begin
      if (xneg) r.left = deflection(nx, str);
      else r.right = deflection(nx, str);
      if (yneg) r.up = deflection(ny, str);
      else r.down = deflection(ny, str);
    end
    return r;
  endfunction

  // single register write, mirrored into the model
  task automatic write_reg(logic [vsam_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      vsam_pkg::REG_AREA_CX:  m_acx = val;
      vsam_pkg::REG_AREA_CY:  m_acy = val;
      vsam_pkg::REG_RADIUS:   m_rad = val;
      vsam_pkg::REG_ASPECT:   m_asp = val;
      vsam_pkg::REG_CMODE:    m_mode = val[1:0];
      vsam_pkg::REG_ONLY_MAX: m_onlymax = val[0];
      vsam_pkg::REG_ENABLE:   m_en = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] cx, logic [15:0] cy, logic [15:0] rad, logic [15:0] asp,
                         logic [1:0] mode, logic omax, logic en);
    write_reg(vsam_pkg::REG_AREA_CX, cx);
    write_reg(vsam_pkg::REG_AREA_CY, cy);
    write_reg(vsam_pkg::REG_RADIUS, rad);
    write_reg(vsam_pkg::REG_ASPECT, asp);
    write_reg(vsam_pkg::REG_CMODE, {14'd0, mode});
    write_reg(vsam_pkg::REG_ONLY_MAX, {15'd0, omax});
    write_reg(vsam_pkg::REG_ENABLE, {15'd0, en});
  endtask

  // offers one touch transfer, with a random gap first, and records its prediction
  // valid stays high after the transfer so items can follow back to back
  task automatic send_touch(logic [1:0] ks, logic [15:0] tx, logic [15:0] ty, logic [15:0] ft);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ft, ty, tx};
    s_axis_tuser <= ks;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_axes.push_back(predict_axes(ks, tx, ty, ft));
  endtask

  // stops offering, waits until every result is back, then lets the block settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_axes.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // receiver: random stalls, plus the long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker: compares each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    axes_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
             m_axis_tdata[63:48], m_axis_tuser};
      if (expected_axes.size() == 0) begin
        $error("unexpected output transfer");
        fails++;
      end else begin
        want = expected_axes.pop_front();
        if (got.left != want.left) begin
          $error("axis_left expected %0d got %0d", want.left, got.left); fails++;
        end
        if (got.right != want.right) begin
          $error("axis_right expected %0d got %0d", want.right, got.right); fails++;
        end
        if (got.up != want.up) begin
          $error("axis_up expected %0d got %0d", want.up, got.up); fails++;
        end
        if (got.down != want.down) begin
          $error("axis_down expected %0d got %0d", want.down, got.down); fails++;
        end
        if (got.active != want.active) begin
          $error("stick_active expected %0d got %0d", want.active, got.active); fails++;
        end
      end
    end
  end

  // corners of the touch fields, every key state, disabled and zero-length cases
  task automatic test_directed;
    set_all(16'h8000, 16'h8000, 16'h2000, 16'h1000, vsam_pkg::CM_AREA, 1'b0, 1'b0);
    send_touch(vsam_pkg::KS_PRESSED, 16'hFFFF, 16'h0000, 16'hFFFF);   // disabled
    drain();
    write_reg(vsam_pkg::REG_ENABLE, 16'd1);
    send_touch(vsam_pkg::KS_UP, 16'h1234, 16'h4321, 16'h0);     // key up
    send_touch(vsam_pkg::KS_PRESSED, 16'h8000, 16'h8000, 16'h0); // zero offset
    send_touch(vsam_pkg::KS_DOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_touch(vsam_pkg::KS_DOWN, 16'h0000, 16'h0000, 16'h0000);
    send_touch(vsam_pkg::KS_DOWN, 16'h8100, 16'h8000, 16'h0);       // below threshold side
    send_touch(vsam_pkg::KS_RELEASED, 16'h0000, 16'hFFFF, 16'h5555);
    send_touch(vsam_pkg::KS_DOWN, 16'hAAAA, 16'h5555, 16'hAAAA);
    drain();
    // strongest axis, spare center mode, zero radius and aspect
    set_all(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, vsam_pkg::CM_AREA_ALT, 1'b1, 1'b1);
    send_touch(vsam_pkg::KS_PRESSED, 16'h0100, 16'hFEFF, 16'h0);
    send_touch(vsam_pkg::KS_DOWN, 16'h0000, 16'hFFFF, 16'h0);
    send_touch(vsam_pkg::KS_DOWN, 16'hFFFF, 16'h0000, 16'h0);
    drain();
    set_all(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, vsam_pkg::CM_ACT, 1'b1, 1'b1);
    send_touch(vsam_pkg::KS_PRESSED, 16'h4000, 16'h4000, 16'h0);
    send_touch(vsam_pkg::KS_DOWN, 16'h4000, 16'hC000, 16'h0);
    send_touch(vsam_pkg::KS_DOWN, 16'h0000, 16'h4000, 16'h0);
    drain();
    set_all(16'h8000, 16'h8000, 16'h1000, 16'h0001, vsam_pkg::CM_SWIPE, 1'b0, 1'b1);
    send_touch(vsam_pkg::KS_PRESSED, 16'h2000, 16'h2000, 16'h0);
    send_touch(vsam_pkg::KS_DOWN, 16'hE000, 16'hE000, 16'h1000);
    send_touch(vsam_pkg::KS_DOWN, 16'h1000, 16'hF000, 16'hFFFF);
    send_touch(vsam_pkg::KS_RELEASED, 16'h9000, 16'h3000, 16'h0800);
    drain();
  endtask

  // mostly press, drag and release gestures with random content, some noise
  task automatic random_gestures(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        send_touch(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_touch(vsam_pkg::KS_PRESSED, 16'($urandom), 16'($urandom),
                   16'($urandom_range(4000)));
        len = $urandom_range(6);
        for (int i = 0; i < len; i++)
          send_touch(vsam_pkg::KS_DOWN, 16'($urandom), 16'($urandom),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8000)));
        send_touch(vsam_pkg::KS_RELEASED, 16'($urandom), 16'($urandom), 16'($urandom));
        sent += len + 2;
      end
    end
  endtask

  task automatic random_config;
    logic [15:0] rad;
    rad = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 16'h3000));
    set_all(16'($urandom), 16'($urandom), rad, 16'($urandom_range(1, 16'h4000)),
            2'($urandom_range(3)), 1'($urandom), ($urandom_range(7) != 0));
  endtask

  // random phases under each idling pattern
  task automatic test_random;
    int idle[4] = '{0, 74, 0, 37};
    int stall[4] = '{0, 0, 74, 37};
    for (int p = 0; p < 8; p++) begin
      send_idle_pct = idle[p % 4];
      recv_stall_pct = stall[p % 4];
      random_config();
      random_gestures(70);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure;
    set_all(16'h8000, 16'h8000, 16'h4000, 16'h1000, vsam_pkg::CM_ACT, 1'b0, 1'b1);
    hold_off = 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_gestures(12);
    join
    drain();
  endtask

  initial begin
    m_acx = '0; m_acy = '0; m_rad = 16'd1; m_asp = 16'd4096;
    m_mode = vsam_pkg::CM_AREA; m_onlymax = 1'b0; m_en = 1'b0;
    m_cx = '0; m_cy = '0; m_lx = '0; m_ly = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
